// ----- design/occ_pkg.sv -----
// occ_pkg: shared types and constants for the order crossover child builder.
// Used by occ_ctrl, occ_datapath and order_crossover_child; no dependencies.
package occ_pkg;

    localparam int VTX_W   = 6;      // vertex id width
    localparam int CUT_W   = 7;      // cut_high width, also scan index width
    localparam int NUM_VTX = 64;     // vertices addressable by a 6-bit id
    localparam int MAX_OUT = 64;     // results per child are capped here
    localparam int NOUT_W  = 7;      // holds 0..MAX_OUT

    typedef struct packed {
        logic [VTX_W-1:0] first_parent_vertex;
        logic [VTX_W-1:0] second_parent_vertex;
        logic [VTX_W-1:0] cut_low;
        logic [CUT_W-1:0] cut_high;
        logic             last_position;
    } t_in_item;

    typedef struct packed {
        logic [VTX_W-1:0] child_vertex;
        logic             last_child;
        logic             cut_error;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_ERR,
        S_SEED_RD,
        S_SEED_PR,
        S_P1_RD,
        S_P1_PR,
        S_P2_RD,
        S_P2_PR,
        S_P3_RD,
        S_P3_PR,
        S_FLUSH
    } t_state;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_INC,
        IDX_ZERO,
        IDX_LOW,
        IDX_HIGH
    } t_idx_op;

    typedef enum logic {
        SRC_FIRST,
        SRC_SECOND
    } t_src;

    // controller -> datapath
    typedef struct packed {
        logic    in_ready;   // load transactions allowed
        logic    rd;         // read both stores at the scan index
        t_idx_op idx_op;
        logic    clear;      // clear marks and per-child counters
        logic    seed;       // mark first-parent vertex just read
        t_src    src;        // candidate source store
        logic    dedup;      // candidate drops if already marked
        logic    take;       // accept candidate into pending slot
        logic    flush;      // send pending as final result
        logic    err;        // send the cut error result
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic load_last;     // last_position transaction accepted
        logic bad;           // cut points invalid
        logic seg_end;       // index is high-1
        logic scan_end;      // index is count-1
        logic high_is_count;
        logic cand;          // current read gives a result
        logic pend_vld;
        logic out_free;      // output register can take a result
        logic cap;           // next result is the last one allowed
    } t_dp_status;

endpackage

// ----- design/occ_ctrl.sv -----
// occ_ctrl: sequencer for the child build (load, seed, three scan phases).
// Depends on occ_pkg; drives occ_datapath through t_dp_cmd.
module occ_ctrl
    import occ_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   w_go;

    // a candidate can only move on if the old pending result has somewhere to go
    assign w_go = !i_status.cand || !i_status.pend_vld || i_status.out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_status.load_last) n_state = S_CHECK;
            end
            S_CHECK: begin
                n_state = i_status.bad ? S_ERR : S_SEED_RD;
            end
            S_ERR: begin
                if (i_status.out_free) n_state = S_IDLE;
            end
            S_SEED_RD: n_state = S_SEED_PR;
            S_SEED_PR: begin
                n_state = i_status.seg_end ? S_P1_RD : S_SEED_RD;
            end
            S_P1_RD: n_state = S_P1_PR;
            S_P1_PR: begin
                if (w_go) begin
                    if (i_status.cand && i_status.cap) n_state = S_FLUSH;
                    else if (i_status.seg_end)         n_state = S_P2_RD;
                    else                               n_state = S_P1_RD;
                end
            end
            S_P2_RD: n_state = S_P2_PR;
            S_P2_PR: begin
                if (w_go) begin
                    if (i_status.cap)                  n_state = S_FLUSH;
                    else if (!i_status.seg_end)        n_state = S_P2_RD;
                    else if (i_status.high_is_count)   n_state = S_FLUSH;
                    else                               n_state = S_P3_RD;
                end
            end
            S_P3_RD: n_state = S_P3_PR;
            S_P3_PR: begin
                if (w_go) begin
                    if (i_status.cand && i_status.cap) n_state = S_FLUSH;
                    else if (i_status.scan_end)        n_state = S_FLUSH;
                    else                               n_state = S_P3_RD;
                end
            end
            S_FLUSH: begin
                if (i_status.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.idx_op   = IDX_HOLD;
        o_cmd.src      = SRC_FIRST;
        case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
            end
            S_CHECK: begin
                if (!i_status.bad) begin
                    o_cmd.clear  = 1'b1;
                    o_cmd.idx_op = IDX_LOW;
                end
            end
            S_ERR: begin
                o_cmd.err = i_status.out_free;
            end
            S_SEED_RD, S_P1_RD, S_P2_RD, S_P3_RD: begin
                o_cmd.rd = 1'b1;
            end
            S_SEED_PR: begin
                o_cmd.seed   = 1'b1;
                o_cmd.idx_op = i_status.seg_end ? IDX_ZERO : IDX_INC;
            end
            S_P1_PR: begin
                o_cmd.src   = SRC_SECOND;
                o_cmd.dedup = 1'b1;
                if (w_go) begin
                    o_cmd.take   = i_status.cand;
                    o_cmd.idx_op = i_status.seg_end ? IDX_LOW : IDX_INC;
                end
            end
            S_P2_PR: begin
                o_cmd.src = SRC_FIRST;
                if (w_go) begin
                    o_cmd.take   = i_status.cand;
                    o_cmd.idx_op = i_status.seg_end ? IDX_HIGH : IDX_INC;
                end
            end
            S_P3_PR: begin
                o_cmd.src   = SRC_SECOND;
                o_cmd.dedup = 1'b1;
                if (w_go) begin
                    o_cmd.take   = i_status.cand;
                    o_cmd.idx_op = IDX_INC;
                end
            end
            S_FLUSH: begin
                o_cmd.flush = i_status.out_free;
            end
            default: begin
                o_cmd.in_ready = 1'b0;
            end
        endcase
    end

    // a push of the final result always finds the pending slot filled
    a_flush_has_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH) |-> i_status.pend_vld)
        else $error("flush with empty pending slot");

    // the build never starts unless a last position was taken in idle
    a_check_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == S_CHECK) |-> $past(i_status.load_last && r_state == S_IDLE))
        else $error("check entered without a last load");

    // loads are refused for the whole build
    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !i_status.load_last)
        else $error("load accepted while building");

endmodule

// ----- design/occ_datapath.sv -----
// occ_datapath: parent stores, membership bitmap, scan index, pending result and
// output register of the child builder. Depends on occ_pkg; driven by occ_ctrl.
module occ_datapath
    import occ_pkg::*;
#(
    parameter int MAX_VERTICES = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    output t_dp_status o_status,
    input  logic       i_in_valid,
    input  t_in_item   i_in_data,
    output logic       o_out_valid,
    output t_out_item  o_out_data,
    input  logic       i_out_stall
);

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = $clog2(MAX_VERTICES + 1);

    logic [VTX_W-1:0] r_fmem [MAX_VERTICES];
    logic [VTX_W-1:0] r_smem [MAX_VERTICES];
    logic [VTX_W-1:0] r_frd;
    logic [VTX_W-1:0] r_srd;

    logic [CW-1:0]    r_load_cnt;
    logic [CW-1:0]    r_count;
    logic [VTX_W-1:0] r_low;
    logic [CUT_W-1:0] r_high;
    logic [CUT_W-1:0] r_idx;
    logic [NUM_VTX-1:0] r_marks;
    logic             r_pend_vld;
    logic [VTX_W-1:0] r_pend_vtx;
    logic [NOUT_W-1:0] r_nout;
    logic             r_out_vld;
    t_out_item        r_out;

    logic             w_accept;
    logic             w_room;
    logic [CUT_W-1:0] w_idx_nx;
    logic [CUT_W-1:0] w_count_ext;
    logic [VTX_W-1:0] w_cand_vtx;
    logic             w_push;
    t_out_item        w_push_data;

    assign w_accept    = i_in_valid && i_cmd.in_ready;
    assign w_room      = r_load_cnt < CW'(MAX_VERTICES);
    assign w_idx_nx    = r_idx + CUT_W'(1);
    assign w_count_ext = CUT_W'(r_count);
    assign w_cand_vtx  = (i_cmd.src == SRC_FIRST) ? r_frd : r_srd;

    // parent stores, one write port for loads and one registered read
    always_ff @(posedge i_clk) begin
        if (w_accept && w_room) begin
            r_fmem[r_load_cnt[AW-1:0]] <= i_in_data.first_parent_vertex;
            r_smem[r_load_cnt[AW-1:0]] <= i_in_data.second_parent_vertex;
        end
        if (i_cmd.rd) begin
            r_frd <= r_fmem[r_idx[AW-1:0]];
            r_srd <= r_smem[r_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_cnt <= '0;
        end else if (w_accept) begin
            if (i_in_data.last_position) r_load_cnt <= '0;
            else if (w_room)             r_load_cnt <= r_load_cnt + CW'(1);
        end
    end

    // cut points and the saturated position count, latched on the last load
    always_ff @(posedge i_clk) begin
        if (w_accept && i_in_data.last_position) begin
            r_low   <= i_in_data.cut_low;
            r_high  <= i_in_data.cut_high;
            r_count <= r_load_cnt + CW'(w_room);
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.idx_op)
            IDX_INC:  r_idx <= w_idx_nx;
            IDX_ZERO: r_idx <= '0;
            IDX_LOW:  r_idx <= CUT_W'(r_low);
            IDX_HIGH: r_idx <= r_high;
            default:  r_idx <= r_idx;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            r_marks <= '0;
        end else if (i_cmd.seed) begin
            r_marks[r_frd] <= 1'b1;
        end else if (i_cmd.take && i_cmd.dedup) begin
            r_marks[w_cand_vtx] <= 1'b1;
        end
    end

    // pending slot: one result held back so the final one can carry last_child
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_vld <= 1'b0;
            r_nout     <= '0;
        end else if (i_cmd.clear) begin
            r_pend_vld <= 1'b0;
            r_nout     <= '0;
        end else if (i_cmd.take) begin
            r_pend_vld <= 1'b1;
            r_nout     <= r_nout + NOUT_W'(1);
        end else if (i_cmd.flush) begin
            r_pend_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_pend_vtx <= w_cand_vtx;
        end
    end

    always_comb begin
        w_push      = 1'b0;
        w_push_data = '0;
        if (i_cmd.err) begin
            w_push                 = 1'b1;
            w_push_data.last_child = 1'b1;
            w_push_data.cut_error  = 1'b1;
        end else if (i_cmd.flush) begin
            w_push                   = 1'b1;
            w_push_data.child_vertex = r_pend_vtx;
            w_push_data.last_child   = 1'b1;
        end else if (i_cmd.take && r_pend_vld) begin
            w_push                   = 1'b1;
            w_push_data.child_vertex = r_pend_vtx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_push) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_out <= w_push_data;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    assign o_status.load_last     = w_accept && i_in_data.last_position;
    assign o_status.bad           = (CUT_W'(r_low) >= r_high) || (r_high > w_count_ext);
    assign o_status.seg_end       = w_idx_nx == r_high;
    assign o_status.scan_end      = w_idx_nx == w_count_ext;
    assign o_status.high_is_count = r_high == w_count_ext;
    assign o_status.cand          = !i_cmd.dedup || !r_marks[w_cand_vtx];
    assign o_status.pend_vld      = r_pend_vld;
    assign o_status.out_free      = !r_out_vld || !i_out_stall;
    assign o_status.cap           = r_nout == NOUT_W'(MAX_OUT - 1);

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && r_out_vld && i_out_stall))
        else $error("output register overwritten while stalled");

    a_err_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.cut_error) |-> r_out.last_child)
        else $error("error result without last_child");

    a_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nout <= NOUT_W'(MAX_OUT))
        else $error("more results than the cap");

    a_load_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in_data.last_position) |=> (r_load_cnt == '0))
        else $error("load count not cleared after last position");

endmodule

// ----- design/order_crossover_child.sv -----
// order_crossover_child: top level of the order crossover child builder.
// Depends on occ_pkg, occ_ctrl and occ_datapath.
//
// Builds one child tour from two parent permutations. Every input transaction
// loads one position of both parents; positions past MAX_VERTICES are dropped.
// The transaction with last_position set also
// carries cut_low/cut_high and starts the build, during which the input is
// stalled. Invalid cuts (cut_low >= cut_high or cut_high above the loaded
// count) yield one result with cut_error and last_child set. Otherwise the
// child comes out as: second-parent vertices before cut_high that are not in
// the first parent's segment, then the segment of the first parent verbatim,
// then unseen second-parent vertices from cut_high on; a 64-bit mark vector
// drops repeats and at most 64 results are sent, the final one flagged with
// last_child. The build walks the parent stores through their single registered
// read port, each position read in a read state followed by a process state, and
// output stalls hold it. A result sits in an output register, so new loads are
// taken while the final result waits.
module order_crossover_child
    import occ_pkg::*;
#(
    parameter int MAX_VERTICES = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in_data,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_item o_out_data,
    input  logic      i_out_stall
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    occ_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    occ_datapath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    // input is only taken while the sequencer sits idle
    assign o_in_stall = !w_cmd.in_ready;

endmodule

// ----- tb/sv/testbench.sv -----
// testbench: self-checking bench for order_crossover_child.
// Depends on occ_pkg and the order_crossover_child RTL; reads no files.
// A directed table, then random tours; results are checked against a local child predictor or a typed row's result.
module testbench
    import occ_pkg::*;
();

    localparam int MAX_VTX     = 64;
    localparam int ITEM_TARGET = 360;   // no new child starts after this many loads
    localparam int QUIET_AT    = 300;   // no idling on either side from here on
    localparam int HOLD_AT     = 100;   // long receiver hold-off starts here
    localparam int HOLD_CYC    = 400;
    localparam int DRAIN_CYC   = 100;

    // shapes of one child build in the random part
    typedef enum {
        CH_WELL,       // two permutations of one vertex set, valid cuts
        CH_CAP,        // heavy repeats in the segment, child hits the 64 result cap
        CH_BADCUT,     // permutations with arbitrary cut fields, mostly rejected
        CH_NOISE,      // arbitrary vertices, short tours
        CH_OVERFLOW    // more loads than the stores hold
    } t_child_kind;

    // one row of the directed table; want is used only when typed is set
    typedef struct packed {
        t_in_item  item;
        logic      typed;
        t_out_item want;
    } t_stim_row;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    t_in_item  i_in_data;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_data;
    logic      i_out_stall;

    order_crossover_child #(
        .MAX_VERTICES(MAX_VTX)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .o_out_data (o_out_data),
        .i_out_stall(i_out_stall)
    );

    // ---------------------------------------------------------------------
    // Child predictor: its own copy of both parent stores and the load count
    // ---------------------------------------------------------------------
    logic [VTX_W-1:0] first_tour_mem [MAX_VTX];
    logic [VTX_W-1:0] second_tour_mem[MAX_VTX];
    int               loaded_positions;
    logic [NUM_VTX-1:0] vertex_seen;
    t_out_item        child_buf[MAX_OUT];    // results of the latest transaction
    int               child_len;

    t_out_item        child_expect_q[$];     // results still owed by the block
    t_stim_row        stim_table[$];

    int               mismatches;
    int               loads_taken;
    int               idle_pct;              // chance of a gap or stall burst, percent
    bit               quiet;                 // last part of the run: no idling
    bit               hold_done;

    // tour scratch for the random part
    int               tour_a[MAX_VTX];
    int               tour_b[MAX_VTX];

    t_out_item        want_now;

    function automatic t_out_item make_result(input int vtx, input int lst, input int er);
        t_out_item r;
        r.child_vertex = VTX_W'(vtx);
        r.last_child   = 1'(lst);
        r.cut_error    = 1'(er);
        return r;
    endfunction

    function automatic t_in_item make_item(input int fv, input int sv, input int lo,
                                           input int hi, input int lst);
        t_in_item it;
        it.first_parent_vertex  = VTX_W'(fv);
        it.second_parent_vertex = VTX_W'(sv);
        it.cut_low              = VTX_W'(lo);
        it.cut_high             = CUT_W'(hi);
        it.last_position        = 1'(lst);
        return it;
    endfunction

    // Append a second-parent vertex unless the mark vector already has it.
    // Marking happens even once the cap is reached.
    task automatic add_unseen(input logic [VTX_W-1:0] vtx);
        if (!vertex_seen[vtx]) begin
            vertex_seen[vtx] = 1'b1;
            if (child_len < MAX_OUT) begin
                child_buf[child_len] = make_result(int'(vtx), 0, 0);
                child_len++;
            end
        end
    endtask

    // Take one load transaction; fills child_buf with whatever it causes.
    task automatic predict_child(input t_in_item it);
        int pos_cnt;
        int i;
        child_len = 0;
        // stores saturate; further positions are dropped
        if (loaded_positions < MAX_VTX) begin
            first_tour_mem[loaded_positions]  = it.first_parent_vertex;
            second_tour_mem[loaded_positions] = it.second_parent_vertex;
            loaded_positions++;
        end
        if (!it.last_position) return;

        pos_cnt = loaded_positions;
        loaded_positions = 0;      // cleared whatever the outcome

        if (int'(it.cut_low) >= int'(it.cut_high) || int'(it.cut_high) > pos_cnt) begin
            child_buf[0] = make_result(0, 1, 1);
            child_len = 1;
            return;
        end

        // segment vertices are pre-marked so the leading scan skips them
        vertex_seen = '0;
        for (i = int'(it.cut_low); i < int'(it.cut_high); i++)
            vertex_seen[first_tour_mem[i]] = 1'b1;
        for (i = 0; i < int'(it.cut_high); i++)
            add_unseen(second_tour_mem[i]);
        // segment goes out verbatim, repeats included
        for (i = int'(it.cut_low); i < int'(it.cut_high); i++) begin
            if (child_len < MAX_OUT) begin
                child_buf[child_len] = make_result(int'(first_tour_mem[i]), 0, 0);
                child_len++;
            end
        end
        for (i = int'(it.cut_high); i < pos_cnt; i++)
            add_unseen(second_tour_mem[i]);
        if (child_len > 0)
            child_buf[child_len-1].last_child = 1'b1;
    endtask

    // ---------------------------------------------------------------------
    // Clock, timeout
    // ---------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // far beyond the slowest legal run
    initial begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

    // ---------------------------------------------------------------------
    // Sender
    // ---------------------------------------------------------------------

    // Offer one transaction, maybe after a short gap; returns once accepted
    // and the owed results are queued. Valid stays high between back-to-back
    // transactions, so each step sees a single assignment to it.
    task automatic send_item(input t_in_item it, input logic typed, input t_out_item want);
        int k;
        if (!quiet && idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_child(it);
        if (typed) begin
            child_expect_q.push_back(want);
        end else begin
            for (k = 0; k < child_len; k++) child_expect_q.push_back(child_buf[k]);
        end
        loads_taken++;
        if (loads_taken >= QUIET_AT) quiet = 1'b1;
    endtask

    task automatic row(input int fv, input int sv, input int lo, input int hi, input int lst,
                       input int typed, input int wv, input int wl, input int we);
        t_stim_row r;
        r.item  = make_item(fv, sv, lo, hi, lst);
        r.typed = 1'(typed);
        r.want  = make_result(wv, wl, we);
        stim_table.push_back(r);
    endtask

    // Fisher-Yates over tour_b[0..n-1]
    task automatic shuffle_tour_b(input int n);
        int i;
        int j;
        int t;
        for (i = n - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = tour_b[i];
            tour_b[i] = tour_b[j];
            tour_b[j] = t;
        end
    endtask

    // tour_a: cnt distinct vertices; tour_b: the same set in another order
    task automatic make_tours(input int cnt);
        int i;
        for (i = 0; i < MAX_VTX; i++) tour_b[i] = i;
        shuffle_tour_b(MAX_VTX);
        for (i = 0; i < cnt; i++) tour_a[i] = tour_b[i];
        shuffle_tour_b(cnt);
    endtask

    function automatic int pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return $urandom_range(2, 12);
        if (r < 96) return $urandom_range(13, 40);
        return MAX_VTX;
    endfunction

    // Load one full tour pair and close it with the last transaction.
    task automatic run_child(input t_child_kind kind);
        int cnt;
        int n_loads;
        int lo;
        int hi;
        int i;
        int fv;
        int sv;
        t_out_item none;
        none = make_result(0, 0, 0);

        case (kind)
            CH_CAP: begin
                // second parent covers all 64 vertices, segment has few distinct ones
                cnt = MAX_VTX;
                for (i = 0; i < MAX_VTX; i++) tour_b[i] = i;
                shuffle_tour_b(MAX_VTX);
                for (i = 0; i < MAX_VTX; i++) tour_a[i] = $urandom_range(0, 7);
            end
            CH_NOISE: begin
                cnt = $urandom_range(1, 12);
                for (i = 0; i < cnt; i++) begin
                    tour_a[i] = $urandom_range(0, 63);
                    tour_b[i] = $urandom_range(0, 63);
                end
            end
            CH_OVERFLOW: begin
                cnt = MAX_VTX;
                make_tours(cnt);
            end
            default: begin
                cnt = pick_size();
                make_tours(cnt);
            end
        endcase

        lo = $urandom_range(0, cnt - 1);
        hi = $urandom_range(lo + 1, cnt);
        if (kind == CH_CAP) begin
            lo = $urandom_range(0, 3);
            hi = $urandom_range(MAX_VTX - 3, MAX_VTX);
        end else if (kind == CH_BADCUT || (kind == CH_NOISE && $urandom_range(0, 1) == 1)) begin
            lo = $urandom_range(0, 63);
            hi = $urandom_range(0, 127);
        end

        // positions past the store depth carry junk that must be dropped
        n_loads = (kind == CH_OVERFLOW) ? cnt + $urandom_range(1, 6) : cnt;
        for (i = 0; i < n_loads; i++) begin
            fv = (i < MAX_VTX) ? tour_a[i] : $urandom_range(0, 63);
            sv = (i < MAX_VTX) ? tour_b[i] : $urandom_range(0, 63);
            if (i == n_loads - 1)
                send_item(make_item(fv, sv, lo, hi, 1), 1'b0, none);
            else
                send_item(make_item(fv, sv, $urandom_range(0, 63), $urandom_range(0, 127), 0),
                          1'b0, none);
        end
    endtask

    initial begin
        int child_no;
        int r;
        t_stim_row cur;

        mismatches       = 0;
        loads_taken      = 0;
        loaded_positions = 0;
        child_len        = 0;
        idle_pct         = 0;
        quiet            = 1'b0;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;

        // Directed table. Typed rows give the expected result directly;
        // the rest are left to the predictor. Cut fields on loads that are
        // not last are junk on purpose: the block must ignore them.
        // single position covered by the segment: child is that vertex
        row(63, 63, 0, 1, 1,     1, 63, 1, 0);
        // cut_high above the loaded count
        row(0, 0, 0, 64, 1,      1, 0, 1, 1);
        // cut_high of zero
        row(5, 7, 0, 0, 1,       1, 0, 1, 1);
        // both cut fields at their maximum
        row(10, 20, 63, 127, 1,  1, 0, 1, 1);
        // cut_low above cut_high
        row(33, 12, 63, 1, 1,    1, 0, 1, 1);
        // empty segment after three loads
        row(1, 2, 63, 127, 0,    0, 0, 0, 0);
        row(2, 3, 0, 0, 0,       0, 0, 0, 0);
        row(3, 1, 2, 2, 1,       1, 0, 1, 1);
        // reversed tour, inner segment
        row(0, 3, 21, 42, 0,     0, 0, 0, 0);
        row(1, 2, 0, 0, 0,       0, 0, 0, 0);
        row(2, 1, 0, 0, 0,       0, 0, 0, 0);
        row(3, 0, 1, 3, 1,       0, 0, 0, 0);
        // repeats in both parents: segment repeats all go out, second
        // parent keeps its first occurrence only
        row(7, 9, 0, 0, 0,       0, 0, 0, 0);
        row(7, 9, 0, 0, 0,       0, 0, 0, 0);
        row(7, 4, 0, 0, 0,       0, 0, 0, 0);
        row(9, 63, 0, 0, 0,      0, 0, 0, 0);
        row(4, 0, 0, 3, 1,       0, 0, 0, 0);
        // segment is the whole tour, nothing from the second parent
        row(42, 63, 0, 0, 0,     0, 0, 0, 0);
        row(21, 21, 0, 0, 0,     0, 0, 0, 0);
        row(63, 42, 0, 3, 1,     0, 0, 0, 0);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stim_table[k]) begin
            cur = stim_table[k];
            send_item(cur.item, cur.typed, cur.want);
        end

        // Random part: mostly well-formed tour pairs; one forced cap case
        // and one forced store overflow early on.
        child_no = 0;
        while (loads_taken < ITEM_TARGET) begin
            r = $urandom_range(0, 2);
            idle_pct = (r == 0) ? 0 : ((r == 1) ? 15 : 40);
            if (child_no == 1) begin
                run_child(CH_CAP);
            end else if (child_no == 3) begin
                run_child(CH_OVERFLOW);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 72)      run_child(CH_WELL);
                else if (r < 84) run_child(CH_BADCUT);
                else if (r < 97) run_child(CH_NOISE);
                else             run_child(CH_CAP);
            end
            child_no++;
        end
        i_in_valid <= 1'b0;

        // drain, then give a stray extra result time to show up
        while (child_expect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // ---------------------------------------------------------------------
    // Receiver: random stall bursts, plus one long hold-off so the block
    // fills up and pushes back on its input
    // ---------------------------------------------------------------------
    initial begin
        hold_done = 1'b0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!hold_done && loads_taken >= HOLD_AT) begin
                hold_done = 1'b1;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYC) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else if (!quiet && idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Result checker: every accepted result against the oldest owed one
    // ---------------------------------------------------------------------
    task automatic field_mismatch(input string fname, input int exp_v, input int act_v);
        $display("%0t: %s expected %0d actual %0d", $time, fname, exp_v, act_v);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (child_expect_q.size() == 0) begin
                $display("%0t: unexpected transaction, expected none actual %0d/%0d/%0d",
                         $time, o_out_data.child_vertex, o_out_data.last_child,
                         o_out_data.cut_error);
                mismatches++;
            end else begin
                want_now = child_expect_q.pop_front();
                if (want_now.child_vertex !== o_out_data.child_vertex)
                    field_mismatch("child_vertex", int'(want_now.child_vertex),
                                   int'(o_out_data.child_vertex));
                if (want_now.last_child !== o_out_data.last_child)
                    field_mismatch("last_child", int'(want_now.last_child),
                                   int'(o_out_data.last_child));
                if (want_now.cut_error !== o_out_data.cut_error)
                    field_mismatch("cut_error", int'(want_now.cut_error),
                                   int'(o_out_data.cut_error));
            end
        end
    end

endmodule

// ----- sim.f -----
design/occ_pkg.sv
design/occ_ctrl.sv
design/occ_datapath.sv
design/order_crossover_child.sv
tb/sv/testbench.sv
